// ----- design/slot_allocator_with_dirty_tracking_unit_defines.svh -----
// Assertion macros for the slot allocator with dirty tracking.
// Included by the top level; expects clk and arst_n in scope.
`ifndef SLOT_ALLOCATOR_WITH_DIRTY_TRACKING_UNIT_DEFINES_SVH
`define SLOT_ALLOCATOR_WITH_DIRTY_TRACKING_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SADT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SADT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/sadt_pkg.sv -----
// Shared types and codes for the slot allocator with dirty tracking.
// No dependencies.
`default_nettype none

package sadt_pkg;

	localparam int CMD_W    = 3;
	localparam int HANDLE_W = 5;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;

	localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_GET    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_UPLOAD = 3'd4;

	localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_BAD  = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_NONE = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN
	} state_t;

endpackage

`default_nettype wire

// ----- design/slot_allocator_with_dirty_tracking_unit.sv -----
// Top level of the slot allocator with dirty tracking: control, flags and memories.
// Depends on sadt_pkg, sadt_ram and slot_allocator_with_dirty_tracking_unit_defines.svh.
//
// A request is taken when start is high and busy is low. For add, remove, update and
// get, the accepting cycle reads the entry and link memories, and the next cycle
// decides, writes back and presents the single result with done high, while busy is
// high. Codes 5 to 7 are taken and give no result. Upload snapshots and clears the
// dirty marks, then walks the entry memory one slot per cycle through its read port;
// it presents a result for each dirty slot and finishes on the highest one. With
// nothing dirty it answers once, like the short commands. Results are shown for one
// cycle only: the receiver has no way to stall them.
`default_nettype none
`include "slot_allocator_with_dirty_tracking_unit_defines.svh"

module slot_allocator_with_dirty_tracking_unit
	import sadt_pkg::*;
#(
	parameter int SLOTS      = 32,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [CMD_W-1:0]    cmd,
	input  wire logic [HANDLE_W-1:0] handle,
	input  wire logic [VALUE_W-1:0]  value,
	output logic                     done,
	output logic [HANDLE_W-1:0]      handle_res,
	output logic [VALUE_W-1:0]       value_res,
	output logic [STATUS_W-1:0]      status,
	output logic                     last
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int CMP_W = (CNT_W > HANDLE_W) ? CNT_W : HANDLE_W;
	localparam int WIDE_W = 64;

	state_t state_q, state_d;

	logic [CMD_W-1:0]      cmd_q;
	logic [HANDLE_W-1:0]   h_q;
	logic [DATA_WIDTH-1:0] v_q;
	logic [SLOTS-1:0]      free_q;
	logic [SLOTS-1:0]      dirty_q;
	logic [SLOTS-1:0]      snap_q;
	logic [CNT_W-1:0]      used_q;
	logic [CNT_W-1:0]      free_head_q;
	logic [IDX_W-1:0]      scan_q;
	logic                  vld_s1;
	logic [IDX_W-1:0]      idx_s1;

	logic [DATA_WIDTH-1:0] ent_rdata;
	logic [CNT_W-1:0]      link_rdata;
	logic                  ent_we;
	logic [IDX_W-1:0]      ent_waddr;
	logic                  ent_re;
	logic [IDX_W-1:0]      ent_raddr;
	logic                  link_we;
	logic                  accept;

	logic [CMP_W-1:0]      h_in_ext, h_ext, slot_ext;
	logic [IDX_W-1:0]      h_in_idx, h_idx, fh_idx, slot_idx;
	logic [WIDE_W-1:0]     v_in_wide, v_wide, r_wide;
	logic                  from_free, fresh, live, scan_emit;
	logic [SLOTS-1:0]      remain;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);

	assign h_in_ext  = CMP_W'(handle);
	assign h_in_idx  = h_in_ext[IDX_W-1:0];
	assign h_ext     = CMP_W'(h_q);
	assign h_idx     = h_ext[IDX_W-1:0];
	assign fh_idx    = free_head_q[IDX_W-1:0];
	assign v_in_wide = WIDE_W'(value);
	assign v_wide    = WIDE_W'(v_q);
	assign r_wide    = WIDE_W'(ent_rdata);

	// A slot on the free list is reused only if the head really points at a free slot.
	assign from_free = (free_head_q != used_q) && (free_head_q < CNT_W'(SLOTS))
		&& free_q[fh_idx];
	assign fresh     = (used_q < CNT_W'(SLOTS));
	assign slot_idx  = from_free ? fh_idx : used_q[IDX_W-1:0];
	assign slot_ext  = CMP_W'(slot_idx);
	assign live      = (h_ext < CMP_W'(used_q)) && !free_q[h_idx];

	assign scan_emit = (state_q == ST_SCAN) && vld_s1 && snap_q[idx_s1];
	assign remain    = snap_q & ~(SLOTS'(1) << idx_s1);

	// The entry read is issued in the accepting cycle and consumed in the next; busy
	// holds off any other access in between, so no forwarding is needed.
	assign ent_re    = accept || (state_q == ST_SCAN);
	assign ent_raddr = (state_q == ST_SCAN) ? scan_q : h_in_idx;

	always_comb begin
		ent_we    = 1'b0;
		ent_waddr = h_idx;
		link_we   = 1'b0;
		if (state_q == ST_EXEC) begin
			unique case (cmd_q)
				CMD_ADD: begin
					ent_we    = from_free || fresh;
					ent_waddr = slot_idx;
				end
				CMD_REMOVE: link_we = live;
				CMD_UPDATE: ent_we  = live;
				default: ;
			endcase
		end
	end

	sadt_ram #(
		.DEPTH(SLOTS),
		.WIDTH(DATA_WIDTH)
	) u_entry_ram (
		.clk  (clk),
		.we   (ent_we),
		.waddr(ent_waddr),
		.wdata(v_q),
		.re   (ent_re),
		.raddr(ent_raddr),
		.rdata(ent_rdata)
	);

	sadt_ram #(
		.DEPTH(SLOTS),
		.WIDTH(CNT_W)
	) u_link_ram (
		.clk  (clk),
		.we   (link_we),
		.waddr(h_idx),
		.wdata(free_head_q),
		.re   (accept),
		.raddr(fh_idx),
		.rdata(link_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (cmd == CMD_ADD || cmd == CMD_REMOVE || cmd == CMD_UPDATE
						|| cmd == CMD_GET) begin
						state_d = ST_EXEC;
					end else if (cmd == CMD_UPLOAD) begin
						state_d = (dirty_q != '0) ? ST_SCAN : ST_EXEC;
					end
				end
			end
			ST_EXEC: state_d = ST_IDLE;
			ST_SCAN: begin
				if (scan_emit && remain == '0) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		done       = 1'b0;
		handle_res = '0;
		value_res  = '0;
		status     = STAT_OK;
		last       = 1'b0;
		unique case (state_q)
			ST_EXEC: begin
				done = 1'b1;
				last = 1'b1;
				unique case (cmd_q)
					CMD_ADD: begin
						if (from_free || fresh) begin
							handle_res = slot_ext[HANDLE_W-1:0];
							value_res  = v_wide[VALUE_W-1:0];
						end else begin
							status = STAT_FULL;
						end
					end
					CMD_REMOVE, CMD_UPDATE, CMD_GET: begin
						handle_res = h_q;
						if (!live) begin
							status = STAT_BAD;
						end else if (cmd_q == CMD_UPDATE) begin
							value_res = v_wide[VALUE_W-1:0];
						end else if (cmd_q == CMD_GET) begin
							value_res = r_wide[VALUE_W-1:0];
						end
					end
					default: status = STAT_NONE;
				endcase
			end
			ST_SCAN: begin
				if (scan_emit) begin
					done       = 1'b1;
					handle_res = idx_s1 <= IDX_W'(SLOTS - 1) ?
						HANDLE_W'(CMP_W'(idx_s1)) : '0;
					value_res  = r_wide[VALUE_W-1:0];
					last       = (remain == '0);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			h_q   <= handle;
			v_q   <= v_in_wide[DATA_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q      <= '0;
			dirty_q     <= '0;
			snap_q      <= '0;
			used_q      <= '0;
			free_head_q <= '0;
			scan_q      <= '0;
			vld_s1      <= 1'b0;
			idx_s1      <= '0;
		end else begin
			if (accept && cmd == CMD_UPLOAD) begin
				snap_q  <= dirty_q;
				dirty_q <= '0;
				scan_q  <= '0;
				vld_s1  <= 1'b0;
			end
			if (state_q == ST_EXEC) begin
				unique case (cmd_q)
					CMD_ADD: begin
						if (from_free) begin
							free_head_q      <= link_rdata;
							free_q[slot_idx] <= 1'b0;
							dirty_q[slot_idx] <= 1'b1;
						end else if (fresh) begin
							used_q            <= used_q + CNT_W'(1);
							free_head_q       <= used_q + CNT_W'(1);
							dirty_q[slot_idx] <= 1'b1;
						end
					end
					CMD_REMOVE: begin
						if (live) begin
							free_q[h_idx]  <= 1'b1;
							dirty_q[h_idx] <= 1'b0;
							free_head_q    <= CNT_W'(h_idx);
						end
					end
					CMD_UPDATE: begin
						if (live) begin
							dirty_q[h_idx] <= 1'b1;
						end
					end
					default: ;
				endcase
			end
			if (state_q == ST_SCAN) begin
				vld_s1 <= 1'b1;
				idx_s1 <= scan_q;
				if (scan_q != IDX_W'(SLOTS - 1)) begin
					scan_q <= scan_q + IDX_W'(1);
				end
				if (scan_emit) begin
					snap_q <= remain;
				end
			end else begin
				vld_s1 <= 1'b0;
			end
		end
	end

	`SADT_ASSERT_NOW(a_done_busy, done, busy, "result strobe outside a busy cycle")
	`SADT_ASSERT_NOW(a_used_range, 1'b1, used_q <= CNT_W'(SLOTS), "used length beyond store size")
	`SADT_ASSERT_NOW(a_head_range, 1'b1, free_head_q <= used_q, "free head beyond used length")
	`SADT_ASSERT_NEXT(a_scan_end, scan_emit && last, !busy, "upload did not end after last result")
	`SADT_ASSERT_NEXT(a_exec_once, state_q == ST_EXEC, !done, "short command gave two results")

endmodule

`default_nettype wire

// ----- design/sadt_ram.sv -----
// Single-port-write, single-port-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module sadt_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the slot allocator with dirty tracking.
// Depends on sadt_pkg and slot_allocator_with_dirty_tracking_unit; a built-in predictor of
// the handle store checks every result, from directed cases first and then random traffic.

module tb_top;
	import sadt_pkg::*;

	localparam int SLOTS      = 32;
	localparam int DATA_WIDTH = 32;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_WAIT = 40;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [HANDLE_W-1:0] slot;
		logic [VALUE_W-1:0]  word;
		logic [STATUS_W-1:0] code;
		logic                is_last;
	} slot_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [CMD_W-1:0]    cmd = '0;
	logic [HANDLE_W-1:0] handle = '0;
	logic [VALUE_W-1:0]  value = '0;
	logic                busy;
	logic                done;
	logic [HANDLE_W-1:0] handle_res;
	logic [VALUE_W-1:0]  value_res;
	logic [STATUS_W-1:0] status;
	logic                last;

	// Predicted state of the slot store.
	logic [VALUE_W-1:0] words [SLOTS];
	logic [5:0]         next_free [SLOTS];
	logic               on_free_list [SLOTS];
	logic               is_dirty [SLOTS];
	logic [6:0]         high_water;
	logic [5:0]         list_head;

	slot_result_t pending_results[$];
	int           err_count = 0;
	int           idle_cycles = 0;
	bit           steady_sender = 1'b0;

	slot_allocator_with_dirty_tracking_unit #(
		.SLOTS(SLOTS),
		.DATA_WIDTH(DATA_WIDTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.handle(handle),
		.value(value),
		.done(done),
		.handle_res(handle_res),
		.value_res(value_res),
		.status(status),
		.last(last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic bit slot_live(input logic [HANDLE_W-1:0] h);
		return (h < high_water) && !on_free_list[h];
	endfunction

	task automatic clear_store_model();
		for (int i = 0; i < SLOTS; i++) begin
			words[i] = '0;
			next_free[i] = '0;
			on_free_list[i] = 1'b0;
			is_dirty[i] = 1'b0;
		end
		high_water = '0;
		list_head = '0;
	endtask

	// Applies one accepted request to the predicted store and queues its results.
	task automatic predict_request(input logic [CMD_W-1:0] c, input logic [HANDLE_W-1:0] h,
			input logic [VALUE_W-1:0] v);
		slot_result_t r;
		slot_result_t batch[$];
		int slot;
		r.slot = h;
		r.word = '0;
		r.code = STAT_OK;
		r.is_last = 1'b1;
		case (c)
			CMD_ADD: begin
				if (list_head != high_water && list_head < SLOTS && on_free_list[list_head]) begin
					slot = list_head;
					list_head = next_free[slot];
					on_free_list[slot] = 1'b0;
				end else if (high_water < SLOTS) begin
					slot = high_water;
					high_water = high_water + 1'b1;
					list_head = high_water[5:0];
				end else begin
					slot = -1;
				end
				if (slot < 0) begin
					r.slot = '0;
					r.code = STAT_FULL;
				end else begin
					words[slot] = v;
					is_dirty[slot] = 1'b1;
					r.slot = slot[HANDLE_W-1:0];
					r.word = v;
				end
				pending_results.push_back(r);
			end
			CMD_REMOVE, CMD_UPDATE, CMD_GET: begin
				if (!slot_live(h)) begin
					r.code = STAT_BAD;
				end else if (c == CMD_REMOVE) begin
					on_free_list[h] = 1'b1;
					next_free[h] = list_head;
					list_head = {1'b0, h};
					is_dirty[h] = 1'b0;
				end else if (c == CMD_UPDATE) begin
					words[h] = v;
					is_dirty[h] = 1'b1;
					r.word = v;
				end else begin
					r.word = words[h];
				end
				pending_results.push_back(r);
			end
			CMD_UPLOAD: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (is_dirty[i]) begin
						r.slot = i[HANDLE_W-1:0];
						r.word = words[i];
						r.is_last = 1'b0;
						batch.push_back(r);
					end
					is_dirty[i] = 1'b0;
				end
				if (batch.size() == 0) begin
					r.slot = '0;
					r.word = '0;
					r.code = STAT_NONE;
					r.is_last = 1'b1;
					pending_results.push_back(r);
				end else begin
					batch[batch.size()-1].is_last = 1'b1;
					foreach (batch[i])
						pending_results.push_back(batch[i]);
				end
			end
			default: ;
		endcase
	endtask

	// Drives one request, waits for the block to take it, then leaves a random gap, or none while steady_sender is set.
	task automatic send_request(input logic [CMD_W-1:0] c, input logic [HANDLE_W-1:0] h,
			input logic [VALUE_W-1:0] v);
		int gap;
		int pick;
		start <= 1'b1;
		cmd <= c;
		handle <= h;
		value <= v;
		do @(posedge clk); while (busy);
		predict_request(c, h, v);
		pick = $urandom_range(99);
		if (steady_sender || pick < 50)
			gap = 0;
		else if (pick < 90)
			gap = $urandom_range(3, 1);
		else
			gap = $urandom_range(40, 8);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic pick_live(output logic [HANDLE_W-1:0] h);
		int cands[$];
		for (int i = 0; i < SLOTS; i++)
			if (slot_live(i[HANDLE_W-1:0]))
				cands.push_back(i);
		if (cands.size() == 0)
			h = HANDLE_W'($urandom_range(SLOTS - 1));
		else
			h = HANDLE_W'(cands[$urandom_range(cands.size() - 1)]);
	endtask

	task automatic test_directed();
		send_request(CMD_UPLOAD, 5'd0, 32'h0);
		send_request(CMD_GET, 5'd0, 32'h0);
		send_request(CMD_REMOVE, 5'd31, 32'hFFFF_FFFF);
		send_request(CMD_UPDATE, 5'd5, 32'h1234_5678);
		send_request(CMD_ADD, 5'd0, 32'h0000_0000);
		send_request(CMD_ADD, 5'd31, 32'hFFFF_FFFF);
		send_request(CMD_ADD, 5'd10, 32'hA5A5_A5A5);
		send_request(CMD_GET, 5'd1, 32'h0);
		send_request(CMD_UPDATE, 5'd0, 32'h5A5A_5A5A);
		send_request(CMD_UPLOAD, 5'd0, 32'h0);
		send_request(CMD_UPLOAD, 5'd0, 32'h0);
		send_request(CMD_REMOVE, 5'd1, 32'h0);
		// A second remove of the same slot must be refused as a free handle.
		send_request(CMD_REMOVE, 5'd1, 32'h0);
		send_request(CMD_GET, 5'd1, 32'h0);
		send_request(CMD_UPDATE, 5'd2, 32'h0);
		send_request(CMD_ADD, 5'd0, 32'h1234_5678);
		send_request(CMD_GET, 5'd3, 32'h0);
		send_request(3'd5, 5'd31, 32'hFFFF_FFFF);
		send_request(3'd6, 5'd0, 32'h0);
		send_request(3'd7, 5'd21, 32'h8000_0001);
		send_request(CMD_REMOVE, 5'd0, 32'h0);
		send_request(CMD_REMOVE, 5'd2, 32'h0);
		send_request(CMD_ADD, 5'd0, 32'hDEAD_BEEF);
		send_request(CMD_ADD, 5'd0, 32'h0BAD_F00D);
		send_request(CMD_UPLOAD, 5'd0, 32'h0);
	endtask

	// Fills every slot, overflows the store and uploads all 32 slots at once.
	task automatic test_full_store();
		repeat (SLOTS + 2)
			send_request(CMD_ADD, HANDLE_W'($urandom_range(31)), $urandom);
		send_request(CMD_GET, 5'd31, 32'h0);
		for (int i = 0; i < SLOTS; i++)
			send_request(CMD_UPDATE, i[HANDLE_W-1:0], $urandom);
		send_request(CMD_UPLOAD, 5'd0, 32'h0);
	endtask

	// Frees every slot in random order, then reuses the most recently freed ones.
	task automatic test_drain_and_reuse();
		int order [SLOTS];
		int j;
		int tmp;
		for (int i = 0; i < SLOTS; i++)
			order[i] = i;
		for (int i = SLOTS - 1; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		for (int i = 0; i < SLOTS; i++)
			send_request(CMD_REMOVE, order[i][HANDLE_W-1:0], $urandom);
		send_request(CMD_UPLOAD, 5'd0, 32'h0);
		send_request(CMD_GET, order[0][HANDLE_W-1:0], 32'h0);
		send_request(CMD_UPDATE, order[5][HANDLE_W-1:0], $urandom);
		repeat (4)
			send_request(CMD_ADD, HANDLE_W'($urandom_range(31)), $urandom);
		send_request(CMD_UPLOAD, 5'd0, 32'h0);
	endtask

	task automatic test_random(input int count, input int add_pct);
		int pick;
		logic [HANDLE_W-1:0] h;
		repeat (count) begin
			if ($urandom_range(99) < add_pct) begin
				send_request(CMD_ADD, HANDLE_W'($urandom_range(31)), $urandom);
			end else begin
				pick = $urandom_range(99);
				pick_live(h);
				if (pick < 25)
					send_request(CMD_REMOVE, h, $urandom);
				else if (pick < 50)
					send_request(CMD_UPDATE, h, $urandom);
				else if (pick < 70)
					send_request(CMD_GET, h, $urandom);
				else if (pick < 80)
					send_request(CMD_UPLOAD, HANDLE_W'($urandom_range(31)), $urandom);
				else if (pick < 93)
					send_request(CMD_W'($urandom_range(3, 1)),
						HANDLE_W'($urandom_range(31)), $urandom);
				else
					send_request(CMD_W'($urandom_range(7, 5)),
						HANDLE_W'($urandom_range(31)), $urandom);
			end
		end
	endtask

	// Each result is held for one cycle only and compared with the oldest prediction.
	always @(posedge clk) begin : check_results
		slot_result_t want;
		slot_result_t got;
		if (arst_n && done) begin
			got.slot = handle_res;
			got.word = value_res;
			got.code = status;
			got.is_last = last;
			if (pending_results.size() == 0) begin
				err_count++;
				if (err_count <= MAX_REPORTS)
					$display("%0t: unexpected result: handle %0d value %h status %0d last %0b",
						$realtime, got.slot, got.word, got.code, got.is_last);
			end else begin
				want = pending_results.pop_front();
				if (got.slot !== want.slot || got.word !== want.word ||
						got.code !== want.code || got.is_last !== want.is_last) begin
					err_count++;
					if (err_count <= MAX_REPORTS)
						$display({"%0t: mismatch: expected handle %0d value %h status %0d ",
							"last %0b, got handle %0d value %h status %0d last %0b"},
							$realtime, want.slot, want.word, want.code, want.is_last,
							got.slot, got.word, got.code, got.is_last);
				end
			end
		end
	end

	// Ends the run when neither a request nor a result has moved for too long.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		clear_store_model();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_store();
		test_drain_and_reuse();
		test_random(70, 60);
		test_random(70, 25);
		test_random(70, 10);
		steady_sender = 1'b1;
		test_random(70, 40);
		steady_sender = 1'b0;
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (err_count == 0 && pending_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
